>>> src/cia_pkg.sv
// ---------------------------------------------------------------------------
// cia_pkg
// shared types and codes for the checked integer unit
// ---------------------------------------------------------------------------
package cia_pkg;

  localparam int DEFAULT_MAX_WIDTH = 64;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  // per-item control that travels down the division stages
  typedef struct packed {
    logic       neg;
    logic [1:0] status;
  } div_ctl_t;

endpackage

>>> src/cia_div.sv
// ---------------------------------------------------------------------------
// cia_div
// pipelined restoring divider, STEPS quotient bits per stage
// ---------------------------------------------------------------------------
module cia_div
  import cia_pkg::*;
#(
  parameter int W     = 64,
  parameter int STEPS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_num,
  input  logic [W-1:0] in_den,
  input  div_ctl_t     in_ctl,
  output logic         out_valid,
  output logic [W-1:0] out_quo,
  output div_ctl_t     out_ctl
);

  localparam int NST = (W + STEPS - 1) / STEPS;
  localparam int TOT = NST * STEPS;

  logic [NST:0]           vld_r;
  logic [TOT-1:0]         num_r [NST+1];
  logic [W-1:0]           rem_r [NST+1];
  logic [W-1:0]           den_r [NST+1];
  div_ctl_t               ctl_r [NST+1];

  always_comb begin
    vld_r[0] = in_valid;
    num_r[0] = TOT'(in_num);
    rem_r[0] = '0;
    den_r[0] = in_den;
    ctl_r[0] = in_ctl;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [TOT-1:0] num_nxt;
    logic [W-1:0]   rem_nxt;
    always_comb begin
      logic [W:0] trial;
      num_nxt = num_r[s];
      rem_nxt = rem_r[s];
      for (int k = 0; k < STEPS; k++) begin
        trial = {rem_nxt, num_nxt[TOT-1]};
        num_nxt = {num_nxt[TOT-2:0], 1'b0};
        if (trial >= {1'b0, den_r[s]}) begin
          trial = trial - {1'b0, den_r[s]};
          num_nxt[0] = 1'b1;
        end
        rem_nxt = trial[W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        num_r[s+1] <= num_nxt;
        rem_r[s+1] <= rem_nxt;
        den_r[s+1] <= den_r[s];
        ctl_r[s+1] <= ctl_r[s];
      end
    end
  end

  assign out_valid = vld_r[NST];
  assign out_quo   = num_r[NST][W-1:0];
  assign out_ctl   = ctl_r[NST];

endmodule

>>> src/checked_integer_alu.sv
// ---------------------------------------------------------------------------
// checked_integer_alu
// add, subtract, multiply and divide at 8 to 64 bits with overflow status
// ---------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall, and
// returns one result per item, in order. Every item runs through the same
// pipeline. First comes an operand stage. Then comes a divider of ceil(W/8)
// stages, W being MAX_WIDTH held to 8..64, each producing one quotient byte.
// Add, subtract and the four-partial-product multiply are done alongside
// the divider and delayed to meet the quotient. Last comes an output
// register. A stall on the result side holds the whole pipeline.
module checked_integer_alu
  import cia_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind[1:0], is_signed[2], width_code[4:3], left_operand[68:5],
  // right_operand[132:69], zero fill to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_bits[63:0], status[65:64], zero fill to 72
  output logic [71:0]  out_tdata
);

  localparam int CAP = (MAX_WIDTH < 8) ? 8 : ((MAX_WIDTH > 64) ? 64 : MAX_WIDTH);
  localparam int W   = CAP;
  localparam int H   = (W + 1) / 2;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---- stage 0: decode, mask, magnitudes
  logic [1:0]   kind;
  logic         sgn;
  logic [1:0]   wc;
  logic [63:0]  a_in, b_in;
  assign kind = in_tdata[1:0];
  assign sgn  = in_tdata[2];
  assign wc   = in_tdata[4:3];
  assign a_in = in_tdata[68:5];
  assign b_in = in_tdata[132:69];

  logic [W-1:0] m0, sb0, a0, b0, ma0, mb0;
  logic         neg0;
  div_ctl_t     dctl0;
  always_comb begin
    logic [6:0] wd;
    wd = 7'd8 << wc;
    if (wd > 7'(W)) wd = 7'(W);
    m0  = (wd >= 7'(W)) ? '1 : W'((65'd1 << wd) - 65'd1);
    sb0 = W'(65'd1 << (wd - 7'd1));
    a0  = a_in[W-1:0] & m0;
    b0  = b_in[W-1:0] & m0;
    ma0 = (sgn && (a0 & sb0) != '0) ? ((~a0 + W'(1)) & m0) : a0;
    mb0 = (sgn && (b0 & sb0) != '0) ? ((~b0 + W'(1)) & m0) : b0;
    neg0 = sgn && (((a0 ^ b0) & sb0) != '0);
    dctl0.neg = neg0;
    if (b0 == '0) dctl0.status = ST_DIV_ZERO;
    else if (sgn && a0 == sb0 && b0 == m0) dctl0.status = ST_OVERFLOW;
    else dctl0.status = ST_OK;
  end

  logic         v1_r;
  logic [1:0]   kind1_r;
  logic         sgn1_r, neg1_r;
  logic [W-1:0] m1_r, sb1_r, a1_r, b1_r, ma1_r, mb1_r;
  div_ctl_t     dctl1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
    if (en) begin
      kind1_r <= kind; sgn1_r <= sgn; neg1_r <= neg0;
      m1_r <= m0; sb1_r <= sb0; a1_r <= a0; b1_r <= b0;
      ma1_r <= ma0; mb1_r <= mb0; dctl1_r <= dctl0;
    end
  end

  // ---- stage 1: add/sub finished, multiply partial products
  logic [W-1:0] as_r1;
  logic         as_ov1;
  always_comb begin
    if (kind1_r == KIND_ADD) begin
      as_r1 = (a1_r + b1_r) & m1_r;
      as_ov1 = sgn1_r ? (((a1_r ^ as_r1) & (b1_r ^ as_r1) & sb1_r) != '0)
                      : (as_r1 < a1_r);
    end else begin
      as_r1 = (a1_r - b1_r) & m1_r;
      as_ov1 = sgn1_r ? (((a1_r ^ b1_r) & (a1_r ^ as_r1) & sb1_r) != '0)
                      : (b1_r > a1_r);
    end
  end

  logic [H-1:0] xl, xh, yl, yh;
  assign xl = ma1_r[H-1:0];
  assign yl = mb1_r[H-1:0];
  assign xh = H'(ma1_r >> H);
  assign yh = H'(mb1_r >> H);

  logic         v2_r;
  logic [1:0]   kind2_r;
  logic         sgn2_r, neg2_r, asov2_r;
  logic [W-1:0] m2_r, sb2_r, asr2_r;
  logic [2*H-1:0] ll_r, lh_r, hl_r, hh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      kind2_r <= kind1_r; sgn2_r <= sgn1_r; neg2_r <= neg1_r;
      asov2_r <= as_ov1; m2_r <= m1_r; sb2_r <= sb1_r; asr2_r <= as_r1;
      ll_r <= (2*H)'(xl) * (2*H)'(yl);
      lh_r <= (2*H)'(xl) * (2*H)'(yh);
      hl_r <= (2*H)'(xh) * (2*H)'(yl);
      hh_r <= (2*H)'(xh) * (2*H)'(yh);
    end
  end

  // ---- stage 2: product sum and multiply result/status
  logic [4*H-1:0] prod;
  logic [W-1:0]   mr2;
  logic           mov2;
  always_comb begin
    logic [W-1:0] lo;
    logic         hi_nz, neg;
    prod = (4*H)'(ll_r) + ((4*H)'(lh_r) << H) + ((4*H)'(hl_r) << H)
         + ((4*H)'(hh_r) << (2*H));
    lo = prod[W-1:0];
    hi_nz = (prod >> W) != '0;
    neg = neg2_r && (prod != '0);
    if (sgn2_r) begin
      mov2 = hi_nz || (lo > (neg ? sb2_r : sb2_r - W'(1)));
      mr2 = (neg ? (~lo + W'(1)) : lo) & m2_r;
    end else begin
      mov2 = hi_nz || (lo > m2_r);
      mr2 = lo & m2_r;
    end
  end

  // side-band result for add/sub/mul, carried along to meet the divider
  logic [W-1:0] side_r;
  logic [1:0]   side_st;
  assign side_r  = (kind2_r == KIND_MUL) ? mr2 : asr2_r;
  assign side_st = ((kind2_r == KIND_MUL) ? mov2 : asov2_r) ? ST_OVERFLOW : ST_OK;

  logic         v3_r;
  logic [1:0]   kind3_r, st3_r;
  logic [W-1:0] r3_r, m3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      kind3_r <= kind2_r; st3_r <= side_st; r3_r <= side_r; m3_r <= m2_r;
    end
  end

  // divider starts from stage-1 magnitudes; its depth is matched below
  logic         dv_valid;
  logic [W-1:0] dq;
  div_ctl_t     dctl_o;
  cia_div #(.W(W), .STEPS(8)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r), .in_num(ma1_r), .in_den(mb1_r), .in_ctl(dctl1_r),
    .out_valid(dv_valid), .out_quo(dq), .out_ctl(dctl_o)
  );

  localparam int NST = (W + 7) / 8;
  // delay line so the side result arrives with the quotient (NST >= 1)
  localparam int DLY = (NST > 2) ? NST - 2 : 1;
  logic [1:0]   dk_r [DLY];
  logic [1:0]   ds_r [DLY];
  logic [W-1:0] dr_r [DLY];
  logic [W-1:0] dm_r [DLY];
  logic [DLY-1:0] dv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else if (en) dv_r <= DLY'({dv_r, v3_r});
    if (en) begin
      dk_r[0] <= kind3_r; ds_r[0] <= st3_r; dr_r[0] <= r3_r; dm_r[0] <= m3_r;
      for (int i = 1; i < DLY; i++) begin
        dk_r[i] <= dk_r[i-1]; ds_r[i] <= ds_r[i-1];
        dr_r[i] <= dr_r[i-1]; dm_r[i] <= dm_r[i-1];
      end
    end
  end

  // with a divider of fewer than three stages the side path is the longer
  logic         cv;
  logic [1:0]   ck, cs;
  logic [W-1:0] cr, cm;
  logic [W-1:0] dq_d;
  div_ctl_t     dctl_d;
  logic         dv_d;
  if (NST > 2) begin : g_long
    assign cv = dv_r[DLY-1]; assign ck = dk_r[DLY-1]; assign cs = ds_r[DLY-1];
    assign cr = dr_r[DLY-1]; assign cm = dm_r[DLY-1];
    assign dq_d = dq; assign dctl_d = dctl_o; assign dv_d = dv_valid;
  end else begin : g_short
    logic [W-1:0] q_r [3-NST];
    div_ctl_t     c_r [3-NST];
    logic [2-NST:0] v_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= '0;
      else if (en) v_r <= (3-NST)'({v_r, dv_valid});
      if (en) begin
        q_r[0] <= dq; c_r[0] <= dctl_o;
        for (int i = 1; i < 3 - NST; i++) begin
          q_r[i] <= q_r[i-1]; c_r[i] <= c_r[i-1];
        end
      end
    end
    assign dq_d = q_r[2-NST]; assign dctl_d = c_r[2-NST]; assign dv_d = v_r[2-NST];
    assign cv = dv_r[0]; assign ck = dk_r[0]; assign cs = ds_r[0];
    assign cr = dr_r[0]; assign cm = dm_r[0];
  end

  // ---- combine and output register
  logic [W-1:0] fr;
  logic [1:0]   fs;
  always_comb begin
    if (ck == KIND_DIV) begin
      fs = dctl_d.status;
      if (dctl_d.status != ST_OK) fr = '0;
      else fr = (dctl_d.neg ? (~dq_d + W'(1)) : dq_d) & cm;
    end else begin
      fs = cs;
      fr = cr;
    end
  end

  logic        ov_r;
  logic [63:0] res_r;
  logic [1:0]  st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= cv;
    if (en) begin
      res_r <= 64'(fr);
      st_r  <= fs;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, st_r, res_r};

`ifndef SYNTHESIS
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    cv == dv_d) else $error("divider and side path out of step");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_r != 2'd3)) else $error("bad status code");
  a_divzero_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st_r == ST_DIV_ZERO) |-> (res_r == 64'd0))
    else $error("division by zero with nonzero result");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(res_r) && $stable(st_r)))
    else $error("result changed under stall");
`endif

endmodule

>>> tb/tb_checked_integer_alu.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_checked_integer_alu
// self-checking bench for the checked integer unit: a directed table of
// extremes and error cases, then random items under several idling phases,
// each result compared in order with a behavioural prediction
// ---------------------------------------------------------------------------
module tb_checked_integer_alu;
  import cia_pkg::*;

  localparam int LATENCY     = DEFAULT_MAX_WIDTH / 8 + 3;
  localparam int WATCHDOG    = 20000;
  localparam int N_RANDOM    = 1150;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [63:0] right_operand;
    logic [63:0] left_operand;
    logic [1:0]  width_code;
    logic        is_signed;
    logic [1:0]  kind;
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] result_bits;
  } alu_res_t;

  typedef struct {
    alu_op_t  op;
    logic     known;   // expected value typed into the table
    alu_res_t res;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  alu_res_t expected_results[$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_off = 1'b0;

  always #5 clk = ~clk;

  checked_integer_alu DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [63:0] width_mask(logic [1:0] wc);
    case (wc)
      2'd0: return 64'hFF;
      2'd1: return 64'hFFFF;
      2'd2: return 64'hFFFF_FFFF;
      default: return '1;
    endcase
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t op);
    logic [63:0]  m, sb, a, b, r, ma, mb, q;
    logic [127:0] prod;
    logic [1:0]   st;
    logic         neg;
    m  = width_mask(op.width_code);
    sb = (m >> 1) + 64'd1;
    a  = op.left_operand & m;
    b  = op.right_operand & m;
    r  = '0;
    st = ST_OK;
    ma = (a & sb) ? ((-a) & m) : a;
    mb = (b & sb) ? ((-b) & m) : b;
    neg = ((a ^ b) & sb) != 0;
    case (op.kind)
      KIND_ADD: begin
        r = (a + b) & m;
        if (op.is_signed) begin
          if (((a ^ r) & (b ^ r) & sb) != 0) st = ST_OVERFLOW;
        end else if (r < a) st = ST_OVERFLOW;
      end
      KIND_SUB: begin
        r = (a - b) & m;
        if (op.is_signed) begin
          if (((a ^ b) & (a ^ r) & sb) != 0) st = ST_OVERFLOW;
        end else if (b > a) st = ST_OVERFLOW;
      end
      KIND_MUL: begin
        if (op.is_signed) begin
          prod = {64'd0, ma} * {64'd0, mb};
          if (prod == 0) neg = 1'b0;
          if (prod > {64'd0, neg ? sb : sb - 64'd1}) st = ST_OVERFLOW;
          r = (neg ? -prod[63:0] : prod[63:0]) & m;
        end else begin
          prod = {64'd0, a} * {64'd0, b};
          if (prod > {64'd0, m}) st = ST_OVERFLOW;
          r = prod[63:0] & m;
        end
      end
      default: begin
        if (b == 0) st = ST_DIV_ZERO;
        else if (op.is_signed) begin
          if (a == sb && b == m) st = ST_OVERFLOW;
          else begin
            q = ma / mb;
            r = (neg ? -q : q) & m;
          end
        end else r = a / b;
      end
    endcase
    return '{status: st, result_bits: r};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // operand values weighted towards the edges of the width
  function automatic logic [63:0] pick_operand(logic [1:0] wc);
    logic [63:0] m, v;
    m = width_mask(wc);
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return 64'd1;
      2: return m;                      // all ones, minus one when signed
      3: return m >> 1;                 // signed maximum
      4: return (m >> 1) + 64'd1;       // signed minimum
      5: return v & 64'hF;
      6: return (v & m) | ~m;           // junk above the width
      default: return v;
    endcase
  endfunction

  task automatic send_item(alu_op_t op);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b0, op};
    expected_results.push_back(alu_predict(op));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    alu_res_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else if (!hold_off) idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = out_tdata[65:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", got.result_bits, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.result_bits !== want.result_bits)
            report_mismatch("result_bits", got.result_bits, want.result_bits);
          if (got.status !== want.status)
            report_mismatch("status", {62'd0, got.status}, {62'd0, want.status});
          if (out_tdata[71:66] !== '0)
            report_mismatch("fill bits", {58'd0, out_tdata[71:66]}, '0);
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("checked_integer_alu test failed");
        $finish;
      end
    end
  end

  // long hold-off on the result side while the sender keeps offering items
  initial begin
    wait (stim_done || hold_off);
    if (hold_off) begin
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
    end
  end

  initial begin
    directed_row_t table_rows[$];
    alu_op_t op;
    alu_res_t got_dummy;
    int phase;
    table_rows = '{
      '{'{64'd1, 64'hFF, 2'd0, 1'b0, KIND_ADD}, 1'b1, '{ST_OVERFLOW, 64'd0}},
      '{'{64'd1, 64'h7F, 2'd0, 1'b1, KIND_ADD}, 1'b1, '{ST_OVERFLOW, 64'h80}},
      '{'{64'd1, 64'd0, 2'd1, 1'b0, KIND_SUB}, 1'b1, '{ST_OVERFLOW, 64'hFFFF}},
      '{'{64'd1, 64'h8000, 2'd1, 1'b1, KIND_SUB}, 1'b1, '{ST_OVERFLOW, 64'h7FFF}},
      '{'{'1, '1, 2'd3, 1'b0, KIND_MUL}, 1'b1, '{ST_OVERFLOW, 64'd1}},
      '{'{'1, '1, 2'd3, 1'b1, KIND_MUL}, 1'b1, '{ST_OK, 64'd1}},
      '{'{64'd0, 64'h1234, 2'd2, 1'b0, KIND_DIV}, 1'b1, '{ST_DIV_ZERO, 64'd0}},
      '{'{64'd0, 64'h80, 2'd0, 1'b1, KIND_DIV}, 1'b1, '{ST_DIV_ZERO, 64'd0}},
      '{'{64'hFF, 64'h80, 2'd0, 1'b1, KIND_DIV}, 1'b1, '{ST_OVERFLOW, 64'd0}},
      '{'{64'hFFFF_FFFF, 64'h8000_0000, 2'd2, 1'b1, KIND_DIV}, 1'b1, '{ST_OVERFLOW, 64'd0}},
      '{'{'1, 64'h8000_0000_0000_0000, 2'd3, 1'b1, KIND_DIV}, 1'b1, '{ST_OVERFLOW, 64'd0}},
      '{'{64'hFFFF_FF00_0000_0003, 64'hABCD_0000_0000_0007, 2'd0, 1'b0, KIND_ADD}, 1'b1,
        '{ST_OK, 64'd10}},
      '{'{64'h8000, 64'h8000, 2'd1, 1'b1, KIND_MUL}, 1'b1, '{ST_OVERFLOW, 64'd0}},
      '{'{64'hFF, 64'h80, 2'd0, 1'b1, KIND_MUL}, 1'b1, '{ST_OVERFLOW, 64'h80}},
      '{'{64'h80, 64'h01, 2'd0, 1'b1, KIND_MUL}, 1'b0, '0},
      '{'{64'hFFFF_FFFD, 64'd7, 2'd2, 1'b1, KIND_DIV}, 1'b0, '0},
      '{'{64'd3, 64'hFFF9, 2'd1, 1'b1, KIND_DIV}, 1'b0, '0},
      '{'{64'd3, '1, 2'd3, 1'b0, KIND_DIV}, 1'b0, '0},
      '{'{'1, '1, 2'd3, 1'b0, KIND_ADD}, 1'b0, '0},
      '{'{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 2'd3, 1'b1, KIND_SUB}, 1'b0, '0},
      '{'{64'h0000_0001_0000_0001, 64'hFFFF_FFFF, 2'd2, 1'b0, KIND_MUL}, 1'b0, '0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].known && alu_predict(table_rows[i].op) != table_rows[i].res) begin
        got_dummy = alu_predict(table_rows[i].op);
        report_mismatch("table row vs prediction", got_dummy.result_bits,
                        table_rows[i].res.result_bits);
      end
      send_item(table_rows[i].op);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = n / (N_RANDOM / 5);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        3: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (n == N_RANDOM - 100) hold_off = 1'b1;
      op.kind          = 2'($urandom_range(3));
      op.is_signed     = 1'($urandom_range(1));
      op.width_code    = 2'($urandom_range(3));
      op.left_operand  = pick_operand(op.width_code);
      op.right_operand = pick_operand(op.width_code);
      send_item(op);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("checked_integer_alu test passed");
    end else begin
      $display("checked_integer_alu test failed");
    end
    $finish;
  end

endmodule
